/* design/world_to_screen_projection_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the vertex projection unit
// Concurrent checks clocked on clk_i and masked during reset (rst_ni low).
// ---------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/wsp_pkg.sv */
// ---------------------------------------------------------------------------
// wsp_pkg
// Shared types, codes and helpers of the vertex projection unit.
// ---------------------------------------------------------------------------
package wsp_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MEM_DEPTH   = 32;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned DIM_W       = 14;
  localparam int unsigned MIN_DEPTH_W = 17;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH     = 2'd2;

  localparam logic [DIM_W-1:0]       RST_SCREEN_WIDTH  = 14'd1920;
  localparam logic [DIM_W-1:0]       RST_SCREEN_HEIGHT = 14'd1080;
  localparam logic [MIN_DEPTH_W-1:0] RST_MIN_DEPTH     = 17'd66;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [2:0][WORD_W-1:0]   vec3_t;

  // One multiply-accumulate step issued alongside its matrix read
  typedef struct packed {
    logic       valid;
    logic       proj;   // 0 view matrix, 1 projection matrix
    logic [1:0] row;
    logic [1:0] term;
  } mac_ctl_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XFORM,
    S_DRAIN,
    S_CHECK,
    S_DIVX,
    S_DIVY,
    S_SCALEX,
    S_SCALEY,
    S_SATY,
    S_OUT
  } state_e;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > SAT_HI) begin
      r = word_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = word_t'(SAT_LO);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

endpackage

/* design/wsp_matrix_mem.sv */
// ---------------------------------------------------------------------------
// wsp_matrix_mem
// 32-word matrix store, one write and one registered read per cycle.
// Unwritten words read as identity (per-word valid bits).
// ---------------------------------------------------------------------------
module wsp_matrix_mem #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wsp_pkg::mem_wr_t             wr_i,
  input  logic                         rd_en_i,
  input  logic [wsp_pkg::ADDR_W-1:0]   rd_addr_i,
  output wsp_pkg::word_t               rd_data_o
);
  import wsp_pkg::*;

  localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

  logic [WORD_W-1:0]    mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [WORD_W-1:0]    rd_data_q;
  logic [WORD_W-1:0]    dflt;

  // address = 16*matrix + 4*column + row; diagonal when column == row
  assign dflt = (rd_addr_i[3:2] == rd_addr_i[1:0]) ? ONE : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : dflt;
    end
  end

  assign rd_data_o = word_t'(rd_data_q);

endmodule

/* design/wsp_xform.sv */
// ---------------------------------------------------------------------------
// wsp_xform
// Multiply-accumulate datapath for the view and projection transforms.
// Read data -> multiply -> floor shift and accumulate; rows saturate.
// ---------------------------------------------------------------------------
module wsp_xform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsp_pkg::mac_ctl_t ctl_i,
  input  wsp_pkg::word_t    rd_data_i,
  input  wsp_pkg::vec3_t    point_i,
  output logic              busy_o,
  output wsp_pkg::word_t    clip_x_o,
  output wsp_pkg::word_t    clip_y_o,
  output wsp_pkg::word_t    clip_w_o
);
  import wsp_pkg::*;

  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned ACC_W  = PROD_W - FRAC_BITS + 2;
  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

  mac_ctl_t                  ctl1_q, ctl2_q;
  logic signed [WORD_W-1:0]  opnd;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, term, sum;
  logic signed [WORD_W-1:0]  view_q [4];
  logic signed [WORD_W-1:0]  clip_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // View stage: x, y, z then translation (times one, exact).
  always_comb begin
    if (ctl1_q.proj) begin
      opnd = view_q[ctl1_q.term];
    end else begin
      unique case (ctl1_q.term)
        2'd0:    opnd = $signed(point_i[0]);
        2'd1:    opnd = $signed(point_i[1]);
        2'd2:    opnd = $signed(point_i[2]);
        default: opnd = ONE;
      endcase
    end
  end

  assign term = ACC_W'(prod_q >>> FRAC_BITS);
  assign sum  = ((ctl2_q.term == 2'd0) ? '0 : acc_q) + term;

  always_ff @(posedge clk_i) begin
    if (ctl1_q.valid) begin
      prod_q <= rd_data_i * opnd;
    end
    if (ctl2_q.valid) begin
      acc_q <= sum;
      if (ctl2_q.term == 2'd3) begin
        if (ctl2_q.proj) begin
          clip_q[ctl2_q.row] <= sat32(64'(sum));
        end else begin
          view_q[ctl2_q.row] <= sat32(64'(sum));
        end
      end
    end
  end

  assign busy_o   = ctl1_q.valid | ctl2_q.valid;
  assign clip_x_o = clip_q[0];
  assign clip_y_o = clip_q[1];
  assign clip_w_o = clip_q[3];

endmodule

/* design/wsp_div.sv */
// ---------------------------------------------------------------------------
// wsp_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, den > 0,
// truncated toward zero and saturated to 32 bits. 32 steps.
// ---------------------------------------------------------------------------
module wsp_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wsp_pkg::word_t num_i,
  input  wsp_pkg::word_t den_i,
  output logic           done_o,
  output wsp_pkg::word_t quot_o
);
  import wsp_pkg::*;

  localparam int unsigned NUM_W = WORD_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic [WORD_W-1:0] mag;
  logic [NUM_W-1:0]  num_sh;
  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] rem_q, den_q, nlo_q, quo_q;
  logic [WORD_W:0]   rem2;
  logic              fit;
  logic              neg_q, ovf_q, run_q, done_q;
  logic [CNT_W-1:0]  cnt_q;

  assign mag    = num_i[WORD_W-1] ? (~num_i + 1'b1) : num_i;
  assign num_sh = {mag, {FRAC_BITS{1'b0}}};
  assign hi     = WORD_W'(num_sh[NUM_W-1:WORD_W]);

  assign rem2 = {rem_q, nlo_q[WORD_W-1]};
  assign fit  = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '1);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi;
      ovf_q <= hi >= den_i;   // quotient would need more than 32 bits
      nlo_q <= num_sh[WORD_W-1:0];
      den_q <= den_i;
      neg_q <= num_i[WORD_W-1];
    end else if (run_q) begin
      rem_q <= fit ? WORD_W'(rem2 - {1'b0, den_q}) : WORD_W'(rem2);
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[WORD_W-2:0], fit};
    end
  end

  always_comb begin
    if (ovf_q || quo_q[WORD_W-1]) begin
      quot_o = neg_q ? word_t'(Q_MIN) : word_t'(Q_MAX);
    end else begin
      quot_o = neg_q ? word_t'(~quo_q + 1'b1) : word_t'(quo_q);
    end
  end

  assign done_o = done_q;

endmodule

/* design/world_to_screen_projection_unit.sv */
// ---------------------------------------------------------------------------
// World-to-screen projection unit
//
// Projects a world point through a stored 4x4 view matrix and 4x4 projection
// matrix (column-major, Q16.16 by default) to screen pixels. Pulse start with
// busy low: op=0 writes matrix word word_index (0-15 view, 16-31 projection)
// in that cycle and gives no result; op=1 projects (point_x, point_y,
// point_z, 1). Each point gives exactly one result, shown for a single
// cycle with done_o high; the receiver cannot stall it, so capture it then.
// A point keeps busy high through the cycle that shows its result, and start
// is ignored while busy is high; a point behind the camera skips the divider.
// The time is set by the single matrix memory read port and multiplier (32
// multiply-adds, one per cycle, then a pipeline drain) and by one shared
// bit-serial divider used twice (for x, then for y), then a short
// scale-to-pixel step. Matrices come out of reset as identity; no
// clearing pass is needed. Configuration writes (screen_width,
// screen_height, min_depth) must only be made while busy is low. Points with
// clip w below min_depth, or not positive, give x=y=0, depth=-1.0 and
// on_screen_side_o=0.
// ---------------------------------------------------------------------------
`include "world_to_screen_projection_unit_macros.svh"

module world_to_screen_projection_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [wsp_pkg::ADDR_W-1:0]          word_index_i,
  input  logic signed [wsp_pkg::WORD_W-1:0]   word_value_i,
  input  logic signed [wsp_pkg::WORD_W-1:0]   point_x_i,
  input  logic signed [wsp_pkg::WORD_W-1:0]   point_y_i,
  input  logic signed [wsp_pkg::WORD_W-1:0]   point_z_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // result
  output logic                                done_o,
  output logic signed [wsp_pkg::WORD_W-1:0]   screen_x_o,
  output logic signed [wsp_pkg::WORD_W-1:0]   screen_y_o,
  output logic signed [wsp_pkg::WORD_W-1:0]   depth_o,
  output logic                                on_screen_side_o
);
  import wsp_pkg::*;

  localparam logic signed [WORD_W-1:0] ONE     = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] NEG_ONE = -ONE;
  localparam int unsigned SCALE_W = WORD_W + DIM_W + 2;

  state_e state_q, state_d;

  // configuration registers
  logic [DIM_W-1:0]       width_q, height_q;
  logic [MIN_DEPTH_W-1:0] min_depth_q;
  logic signed [WORD_W-1:0] min_ext;

  // sequencing
  logic [ADDR_W-1:0] step_q;
  mem_wr_t           mem_wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  word_t             rd_data;
  mac_ctl_t          ctl;
  logic              mac_busy;
  word_t             clip_x, clip_y, clip_w;
  logic              behind;

  // divider
  logic  div_start, div_done;
  word_t div_num, div_quot;

  // payload
  vec3_t                     pt_q;
  logic signed [WORD_W-1:0]  ndc_x_q, ndc_y_q;
  logic signed [WORD_W:0]    mul_a;
  logic signed [DIM_W:0]     mul_b;
  logic signed [SCALE_W-1:0] scale_q;
  logic signed [WORD_W-1:0]  sx_q, sy_q, depth_q;
  logic                      side_q;

  // -------------------------------------------------------------------------
  // Sub-units
  // -------------------------------------------------------------------------
  wsp_matrix_mem #(.FRAC_BITS(FRAC_BITS)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  wsp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_i (rd_data),
    .point_i   (pt_q),
    .busy_o    (mac_busy),
    .clip_x_o  (clip_x),
    .clip_y_o  (clip_y),
    .clip_w_o  (clip_w)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (clip_w),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_SCREEN_WIDTH;
      height_q    <= RST_SCREEN_HEIGHT;
      min_depth_q <= RST_MIN_DEPTH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q     <= cfg_data_i[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: height_q    <= cfg_data_i[DIM_W-1:0];
        CFG_MIN_DEPTH:     min_depth_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign min_ext = {{(WORD_W-MIN_DEPTH_W){1'b0}}, min_depth_q};
  assign behind  = (clip_w <= 0) || (clip_w < min_ext);

  // -------------------------------------------------------------------------
  // Sequencer
  // step_q walks 32 multiply-adds: bit 4 picks the matrix, bits 3:2 the row,
  // bits 1:0 the column (term). Rows of the view pass finish long before the
  // projection pass needs them, so the two passes run back to back.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == S_XFORM) ? step_q + 1'b1 : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start && (op_i == OP_POINT)) state_d = S_XFORM;
      S_XFORM:  if (step_q == '1) state_d = S_DRAIN;
      S_DRAIN:  if (!mac_busy) state_d = S_CHECK;
      S_CHECK:  state_d = behind ? S_OUT : S_DIVX;
      S_DIVX:   if (div_done) state_d = S_DIVY;
      S_DIVY:   if (div_done) state_d = S_SCALEX;
      S_SCALEX: state_d = S_SCALEY;
      S_SCALEY: state_d = S_SATY;
      S_SATY:   state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // matrix word = 16*matrix + 4*column + row
  assign rd_addr = {step_q[ADDR_W-1], step_q[1:0], step_q[3:2]};

  always_comb begin
    mem_wr    = '{en: 1'b0, addr: word_index_i, data: word_value_i};
    rd_en     = 1'b0;
    ctl       = '0;
    div_start = 1'b0;
    div_num   = clip_x;
    unique case (state_q)
      S_IDLE: begin
        mem_wr.en = start && (op_i == OP_LOAD);
      end
      S_XFORM: begin
        rd_en     = 1'b1;
        ctl.valid = 1'b1;
        ctl.proj  = step_q[ADDR_W-1];
        ctl.row   = step_q[3:2];
        ctl.term  = step_q[1:0];
      end
      S_CHECK: begin
        div_start = !behind;
      end
      S_DIVX: begin
        div_start = div_done;   // y follows x on the same divider
        div_num   = clip_y;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Screen mapping: x = (ndc_x + 1) * W / 2, y = (1 - ndc_y) * H / 2
  // -------------------------------------------------------------------------
  always_comb begin
    if (state_q == S_SCALEX) begin
      mul_a = (WORD_W+1)'(ndc_x_q) + (WORD_W+1)'(ONE);
      mul_b = {1'b0, width_q};
    end else begin
      mul_a = (WORD_W+1)'(ONE) - (WORD_W+1)'(ndc_y_q);
      mul_b = {1'b0, height_q};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start && (op_i == OP_POINT)) begin
          pt_q <= {point_z_i, point_y_i, point_x_i};
        end
      end
      S_CHECK: begin
        if (behind) begin
          sx_q    <= '0;
          sy_q    <= '0;
          depth_q <= NEG_ONE;
          side_q  <= 1'b0;
        end
      end
      S_DIVX: begin
        if (div_done) ndc_x_q <= div_quot;
      end
      S_DIVY: begin
        if (div_done) ndc_y_q <= div_quot;
      end
      S_SCALEX: begin
        scale_q <= mul_a * mul_b;
      end
      S_SCALEY: begin
        sx_q    <= sat32(64'(scale_q >>> 1));
        scale_q <= mul_a * mul_b;
      end
      S_SATY: begin
        sy_q    <= sat32(64'(scale_q >>> 1));
        depth_q <= clip_w;
        side_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_OUT);
  assign screen_x_o       = sx_q;
  assign screen_y_o       = sy_q;
  assign depth_o          = depth_q;
  assign on_screen_side_o = side_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `WSP_ASSERT_IMP(a_behind_result, done_o && !on_screen_side_o, screen_x_o == 0 && screen_y_o == 0 && depth_o == NEG_ONE, "behind-camera result not cleared")
  `WSP_ASSERT_IMP(a_front_depth, done_o && on_screen_side_o, depth_o > 0 && depth_o >= min_ext, "front result with depth below limit")
  `WSP_ASSERT_NXT(a_single_result, done_o, !done_o && !busy, "result strobe longer than one cycle")
  `WSP_ASSERT_NXT(a_point_busy, start && !busy && op_i == OP_POINT, busy && !done_o, "point accepted without going busy")
  `WSP_ASSERT_IMP(a_div_after_mac, div_start, !mac_busy && clip_w > 0, "divide started before clip w settled")

endmodule
